// ===== rtl/k_way_sorted_merge_unit_defines.svh =====
// Assertion macros shared by the merge unit RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef K_WAY_SORTED_MERGE_UNIT_DEFINES_SVH
`define K_WAY_SORTED_MERGE_UNIT_DEFINES_SVH

// same-cycle implication
`define KWM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KWM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kwm_pkg.sv =====
// Package for the k-way sorted merge unit: transaction structs, command codes,
// compare-unit control struct and default sizes. No dependencies.
`timescale 1ns / 1ps

package kwm_pkg;

  localparam int NUM_LISTS_DEF  = 8;
  localparam int LIST_DEPTH_DEF = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_POP    = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [2:0]         list_index;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] merged_value;
    logic [2:0]         source_list;
    logic               empty_res;
    logic               rejected;
  } out_t;

  typedef struct packed {
    logic clr;
    logic en;
  } cmp_ctl_t;

endpackage

// ===== rtl/kwm_store.sv =====
// Element store: one write port, one registered read port.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module kwm_store #(
  parameter int VB = 32,
  parameter int AW = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [VB-1:0] wdata,
  output logic [VB-1:0] rdata
);

  localparam int DEPTH = 1 << AW;

  logic [VB-1:0] mem [DEPTH];
  logic [VB-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/kwm_cmp.sv =====
// Shared signed compare/select unit; tracks the running minimum head.
// Depends on kwm_pkg (cmp_ctl_t).
`timescale 1ns / 1ps

module kwm_cmp #(
  parameter int VB = 32,
  parameter int LW = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  kwm_pkg::cmp_ctl_t ctl,
  input  logic [VB-1:0]     cand_val,
  input  logic [LW-1:0]     cand_idx,
  output logic [VB-1:0]     best_val,
  output logic [LW-1:0]     best_idx,
  output logic              found
);

  import kwm_pkg::*;

  logic [VB-1:0] best_val_r;
  logic [LW-1:0] best_idx_r;
  logic          found_r;
  logic          take;

  // later list wins ties
  assign take = ctl.en && (!found_r || ($signed(cand_val) <= $signed(best_val_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.clr) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_val_r <= cand_val;
      best_idx_r <= cand_idx;
    end
  end

  assign best_val = best_val_r;
  assign best_idx = best_idx_r;
  assign found    = found_r;

endmodule

// ===== rtl/k_way_sorted_merge_unit.sv =====
// Channel | dir | handshake           | payload
// in      | in  | in_valid / in_ready  | in_data  (kwm_pkg::in_t)
// out     | out | out_valid / out_ready| out_data (kwm_pkg::out_t)
//
// Top level of the k-way sorted merge unit; uses kwm_pkg, kwm_store, kwm_cmp.
// Clear, append and unused commands: decoded in S_DECODE, then the result goes out through S_EMIT.
// Pop: S_SCAN, S_DRAIN, S_COMMIT, then S_EMIT, one store read per list through the shared compare unit.
// A new transaction is taken only in S_IDLE, which follows the load of the result into the output register.
// rst_n is synchronous, active low; it zeroes all list positions. Store contents are not reset.
// A stalled output holds the unit in its emit step; one result may wait while input is taken.
`timescale 1ns / 1ps

`include "k_way_sorted_merge_unit_defines.svh"

module k_way_sorted_merge_unit #(
  parameter int NUM_LISTS  = kwm_pkg::NUM_LISTS_DEF,
  parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF,
  parameter int VALUE_BITS = kwm_pkg::VALUE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  kwm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output kwm_pkg::out_t out_data
);

  import kwm_pkg::*;

  localparam int LW = $clog2(NUM_LISTS);
  localparam int DW = $clog2(LIST_DEPTH);
  localparam int PW = $clog2(LIST_DEPTH + 1);
  localparam int AW = LW + DW;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_SCAN   = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_COMMIT = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  in_t           txn_r;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic          pend_vld_r, pend_vld_nxt;
  logic [LW-1:0] pend_idx_r, pend_idx_nxt;
  logic [PW-1:0] rp_r [NUM_LISTS];
  logic [PW-1:0] wp_r [NUM_LISTS];
  out_t          res_r, res_nxt;
  logic          res_ld;
  logic          out_valid_r;
  out_t          out_data_r;

  logic [LW-1:0] idx_list;
  logic [LW-1:0] sel_list;
  logic [PW-1:0] rp_sel;
  logic [PW-1:0] wp_sel;
  logic          idx_ok;
  logic          full;
  logic          clr_ptrs;
  logic          wp_inc;
  logic          rp_inc;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [VALUE_BITS-1:0] mem_wdata;
  logic [VALUE_BITS-1:0] mem_rdata;
  cmp_ctl_t      cmp_ctl;
  logic [VALUE_BITS-1:0] best_val;
  logic [LW-1:0] best_idx;
  logic          cmp_found;
  logic          emit_go;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign idx_list = LW'(txn_r.list_index);
  assign idx_ok   = (32'(txn_r.list_index) < NUM_LISTS);

  always_comb begin
    case (state_r)
      S_SCAN:   sel_list = cnt_r;
      S_COMMIT: sel_list = best_idx;
      default:  sel_list = idx_list;
    endcase
  end

  assign rp_sel = rp_r[sel_list];
  assign wp_sel = wp_r[sel_list];
  assign full   = (wp_sel >= PW'(LIST_DEPTH));

  assign mem_addr  = (state_r == S_SCAN) ? {cnt_r, rp_sel[DW-1:0]}
                                         : {idx_list, wp_sel[DW-1:0]};
  assign mem_wdata = VALUE_BITS'(txn_r.value);

  assign emit_go = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    pend_vld_nxt = 1'b0;
    pend_idx_nxt = pend_idx_r;
    res_nxt      = '0;
    res_ld       = 1'b0;
    clr_ptrs     = 1'b0;
    wp_inc       = 1'b0;
    rp_inc       = 1'b0;
    mem_we       = 1'b0;
    cmp_ctl      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cnt_nxt = '0;
        case (txn_r.cmd)
          CMD_CLEAR: begin
            clr_ptrs  = 1'b1;
            res_ld    = 1'b1;
            state_nxt = S_EMIT;
          end
          CMD_APPEND: begin
            res_ld    = 1'b1;
            state_nxt = S_EMIT;
            if (!idx_ok || full) begin
              res_nxt.rejected = 1'b1;
            end else begin
              mem_we = 1'b1;
              wp_inc = 1'b1;
            end
          end
          CMD_POP: begin
            cmp_ctl.clr = 1'b1;
            state_nxt   = S_SCAN;
          end
          default: begin
            res_ld    = 1'b1;
            state_nxt = S_EMIT;
          end
        endcase
      end
      S_SCAN: begin
        cmp_ctl.en   = pend_vld_r;
        pend_vld_nxt = (rp_sel < wp_sel);
        pend_idx_nxt = cnt_r;
        if (cnt_r == LW'(NUM_LISTS - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + LW'(1);
        end
      end
      S_DRAIN: begin
        cmp_ctl.en = pend_vld_r;
        state_nxt  = S_COMMIT;
      end
      S_COMMIT: begin
        res_ld = 1'b1;
        if (cmp_found) begin
          rp_inc               = 1'b1;
          res_nxt.merged_value = 32'($signed(best_val));
          res_nxt.source_list  = 3'(best_idx);
        end else begin
          res_nxt.empty_res = 1'b1;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      pend_vld_r <= pend_vld_nxt;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      txn_r <= in_data;
    end
    if (res_ld) begin
      res_r <= res_nxt;
    end
    if (emit_go) begin
      out_data_r <= res_r;
    end
    pend_idx_r <= pend_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr_ptrs) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        rp_r[i] <= '0;
        wp_r[i] <= '0;
      end
    end else begin
      if (wp_inc) begin
        wp_r[sel_list] <= wp_sel + PW'(1);
      end
      if (rp_inc) begin
        rp_r[sel_list] <= rp_sel + PW'(1);
      end
    end
  end

  kwm_store #(
    .VB (VALUE_BITS),
    .AW (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  kwm_cmp #(
    .VB (VALUE_BITS),
    .LW (LW)
  ) u_cmp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (cmp_ctl),
    .cand_val (mem_rdata),
    .cand_idx (pend_idx_r),
    .best_val (best_val),
    .best_idx (best_idx),
    .found    (cmp_found)
  );

  `KWM_ASSERT_NXT(a_accept_decode, in_valid && in_ready, state_r == S_DECODE, "accept did not decode")
  `KWM_ASSERT_NOW(a_scan_order, state_r == S_SCAN, rp_sel <= wp_sel, "read past write position")
  `KWM_ASSERT_NOW(a_pop_nonempty, (state_r == S_COMMIT) && cmp_found, rp_sel < wp_sel, "pop from empty list")
  `KWM_ASSERT_NOW(a_flags_excl, out_valid_r, !(out_data_r.empty_res && out_data_r.rejected), "both flags set")
  `KWM_ASSERT_NXT(a_emit_loads, emit_go, out_valid_r && (state_r == S_IDLE), "emit did not load output")

endmodule

// ===== tb/sv/k_way_sorted_merge_unit_test.sv =====
// Testbench for k_way_sorted_merge_unit: directed and random clear/append/pop traffic
// under several idle and stall mixes, checked against a behavioral merge scoreboard.
// Depends on kwm_pkg and the merge unit RTL.
`timescale 1ns / 1ps

module k_way_sorted_merge_unit_test;
  import kwm_pkg::*;

  localparam int NUM_LISTS = NUM_LISTS_DEF;
  localparam int LIST_DEPTH = LIST_DEPTH_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
  localparam int ITEMS_PER_PHASE = 440;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 800000;
  localparam int DRAIN_CYCLES = 40;

  class merge_scoreboard;
    logic signed [31:0] store [NUM_LISTS][LIST_DEPTH];
    int unsigned rd_pos [NUM_LISTS];
    int unsigned wr_pos [NUM_LISTS];
    out_t expected_q [$];
    int errors;

    function new();
      foreach (rd_pos[i]) begin
        rd_pos[i] = 0;
        wr_pos[i] = 0;
      end
      errors = 0;
    endfunction

    function out_t merge_step(in_t t);
      out_t r;
      bit found;
      int best;
      logic signed [31:0] head;
      logic signed [31:0] best_v;
      r = '0;
      found = 1'b0;
      best = 0;
      best_v = '0;
      case (t.cmd)
        CMD_CLEAR: begin
          foreach (rd_pos[i]) begin
            rd_pos[i] = 0;
            wr_pos[i] = 0;
          end
        end
        CMD_APPEND: begin
          if (t.list_index >= NUM_LISTS || wr_pos[t.list_index] >= LIST_DEPTH) begin
            r.rejected = 1'b1;
          end else begin
            store[t.list_index][wr_pos[t.list_index]] = t.value;
            wr_pos[t.list_index]++;
          end
        end
        CMD_POP: begin
          // highest index wins ties, hence <=
          for (int i = 0; i < NUM_LISTS; i++) begin
            if (rd_pos[i] < wr_pos[i]) begin
              head = store[i][rd_pos[i]];
              if (!found || head <= best_v) begin
                found = 1'b1;
                best = i;
                best_v = head;
              end
            end
          end
          if (!found) begin
            r.empty_res = 1'b1;
          end else begin
            r.merged_value = best_v;
            r.source_list = 3'(best);
            rd_pos[best]++;
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_input(in_t t);
      expected_q.push_back(merge_step(t));
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("merge: unexpected result value %0d list %0d empty %0b rej %0b",
                   got.merged_value, got.source_list, got.empty_res, got.rejected);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.merged_value !== exp_r.merged_value || got.source_list !== exp_r.source_list ||
          got.empty_res !== exp_r.empty_res || got.rejected !== exp_r.rejected) begin
        errors++;
        if (errors <= 10)
          $display("merge: exp value %0d list %0d empty %0b rej %0b / got %0d %0d %0b %0b",
                   exp_r.merged_value, exp_r.source_list, exp_r.empty_res, exp_r.rejected,
                   got.merged_value, got.source_list, got.empty_res, got.rejected);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  merge_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int n_items = 0;
  logic hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;

  k_way_sorted_merge_unit u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("k_way_sorted_merge_unit: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // receiver: random stalls, plus one long hold-off to back up the unit
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      out_ready <= 1'b0;
      hold_cnt++;
      if (hold_cnt >= HOLD_CYCLES) hold_done = 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic drive_item(logic [1:0] c, logic [2:0] idx, logic signed [31:0] v);
    in_t t;
    t.cmd = c;
    t.list_index = idx;
    t.value = v;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    if (c != CMD_UNUSED) n_items++;
  endtask

  // clear, then ascending appends interleaved with pops, with some noise mixed in
  task automatic run_merge_batch();
    int n_app [NUM_LISTS];
    longint tail [NUM_LISTS];
    bit narrow;
    int total;
    int pops_left;
    int pick;
    drive_item(CMD_CLEAR, 3'($urandom), int'($urandom));
    narrow = $urandom_range(1);
    total = 0;
    for (int i = 0; i < NUM_LISTS; i++) begin
      n_app[i] = $urandom_range(6);
      if (narrow) tail[i] = longint'($urandom_range(4)) - 2;
      else if ($urandom_range(7) == 0) tail[i] = VAL_MIN;
      else tail[i] = int'($urandom);
      total += n_app[i];
    end
    if ($urandom_range(3) == 0) begin
      pick = $urandom_range(NUM_LISTS - 1);
      total -= n_app[pick];
      n_app[pick] = $urandom_range(LIST_DEPTH + 3, LIST_DEPTH);
      total += n_app[pick];
    end
    pops_left = total + $urandom_range(2);
    while (total > 0 || pops_left > 0) begin
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0: drive_item(CMD_UNUSED, 3'($urandom), int'($urandom));
          1: drive_item(CMD_APPEND, 3'($urandom), int'($urandom));
          2: drive_item(CMD_POP, 3'($urandom), int'($urandom));
          default: begin
            if ($urandom_range(4) == 0) drive_item(CMD_CLEAR, 3'($urandom), int'($urandom));
            else drive_item(CMD_POP, 3'($urandom), int'($urandom));
          end
        endcase
      end else if (total > 0 && (pops_left == 0 || $urandom_range(1) == 0)) begin
        pick = $urandom_range(NUM_LISTS - 1);
        while (n_app[pick] == 0) pick = (pick + 1) % NUM_LISTS;
        if (narrow) tail[pick] += $urandom_range(1);
        else tail[pick] += $urandom_range(1 << 20);
        if (tail[pick] > VAL_MAX) tail[pick] = VAL_MAX;
        drive_item(CMD_APPEND, 3'(pick), 32'(tail[pick]));
        n_app[pick]--;
        total--;
      end else begin
        drive_item(CMD_POP, 3'($urandom), int'($urandom));
        pops_left--;
      end
    end
  endtask

  initial begin
    do @(posedge clk); while (!rst_n);

    drive_item(CMD_POP, 3'd0, 32'sd0);
    drive_item(CMD_UNUSED, 3'd7, -32'sd1);
    drive_item(CMD_APPEND, 3'd0, VAL_MIN);
    drive_item(CMD_APPEND, 3'd7, VAL_MAX);
    drive_item(CMD_APPEND, 3'd2, 32'sd5);
    drive_item(CMD_APPEND, 3'd5, 32'sd5);
    drive_item(CMD_APPEND, 3'd3, 32'sd5);
    drive_item(CMD_APPEND, 3'd1, -32'sd1);
    drive_item(CMD_APPEND, 3'd1, 32'sd0);
    repeat (6) drive_item(CMD_POP, 3'd0, 32'sd0);
    // out-of-order list contents
    drive_item(CMD_APPEND, 3'd4, 32'sd10);
    drive_item(CMD_APPEND, 3'd4, 32'sd3);
    repeat (4) drive_item(CMD_POP, 3'd7, VAL_MAX);
    drive_item(CMD_APPEND, 3'd6, 32'sd7);
    drive_item(CMD_CLEAR, 3'd7, VAL_MAX);
    drive_item(CMD_POP, 3'd0, VAL_MIN);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0; stall_pct <= 0; end
        1: begin idle_pct = 83; stall_pct <= 0; end
        2: begin idle_pct = 0; stall_pct <= 83; end
        default: begin idle_pct = 22; stall_pct <= 22; end
      endcase
      while (n_items < (ph + 1) * ITEMS_PER_PHASE + 24) begin
        run_merge_batch();
        if (ph == 0 && !hold_go) hold_go <= 1'b1;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("k_way_sorted_merge_unit: match");
    end else begin
      $display("k_way_sorted_merge_unit: mismatch");
    end
    $finish;
  end

endmodule
